### src/paged_mono_framebuffer_engine_core_defines.svh
`ifndef PAGED_MONO_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH
`define PAGED_MONO_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset
`define PMFB_ASSERT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset
`define PMFB_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### src/pmfb_pkg.sv
package pmfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam logic [2:0] ACT_POINT   = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_INVERT  = 3'd2;
    localparam logic [2:0] ACT_FILL    = 3'd3;
    localparam logic [2:0] ACT_OUTLINE = 3'd4;
    localparam logic [2:0] ACT_BLIT    = 3'd5;
    localparam logic [2:0] ACT_READ    = 3'd6;
    localparam logic [2:0] ACT_INV_ALL = 3'd7;

    // Write-back operation applied to the byte read from the store
    localparam logic [1:0] K_OR   = 2'd0;
    localparam logic [1:0] K_ANDN = 2'd1;
    localparam logic [1:0] K_XOR  = 2'd2;
    localparam logic [1:0] K_READ = 2'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] area_width;
        logic [7:0] area_height;
        logic [2:0] band;
        logic [7:0] col_offset;
        logic [7:0] image_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
    } t_out_item;

    // Bits of one page whose rows fall in the wrapped span top .. top+height-1
    function automatic logic [7:0] f_row_mask(input logic [2:0] page,
                                              input logic [7:0] top,
                                              input logic [7:0] height);
        logic [7:0] m;
        logic [7:0] row;
        logic [7:0] span_off;
        m = 8'h00;
        for (int b = 0; b < 8; b++) begin
            row      = {2'b00, page, 3'(b)};
            span_off = row - top;
            m[b]     = (span_off < height);
        end
        return m;
    endfunction

    // Single bit of one page for one pixel row, zero if the row is elsewhere
    function automatic logic [7:0] f_row_bit(input logic [2:0] page,
                                             input logic [7:0] row);
        logic [7:0] m;
        m = 8'h00;
        if (row[7:3] == {2'b00, page}) begin
            m = 8'h01 << row[2:0];
        end
        return m;
    endfunction

endpackage

### src/paged_mono_framebuffer_engine_core.sv
// Page-organised monochrome frame buffer of PAGES x COLUMNS bytes, eight vertical pixels per
// byte with bit 0 at the top, held in one memory with a single read and a single write port.
// Every action walks the bytes it visits at one byte per cycle, a read-modify-write for all
// but read, which only reads: point and read visit one byte, blit one or two, clear, invert,
// fill and outline rectangles area_width x PAGES (outline with zero width 2 x PAGES), and
// invert all PAGES x COLUMNS. After reset the block clears the store in a pass over all
// PAGES x COLUMNS bytes before its first item is taken. One result per item, held in an
// output register, so the next item is taken while a result still waits.
module paged_mono_framebuffer_engine_core
    import pmfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic          s_res_valid;
    logic          s_res_ready;
    t_out_item     s_res;
    logic          s_mem_re;
    logic [AW-1:0] s_mem_raddr;
    logic [7:0]    s_mem_rdata;
    logic          s_mem_we;
    logic [AW-1:0] s_mem_waddr;
    logic [7:0]    s_mem_wdata;

    logic          r_out_valid;
    t_out_item     r_out;

    pmfb_walk #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (s_res_valid),
        .i_res_ready (s_res_ready),
        .o_res       (s_res),
        .o_mem_re    (s_mem_re),
        .o_mem_raddr (s_mem_raddr),
        .i_mem_rdata (s_mem_rdata),
        .o_mem_we    (s_mem_we),
        .o_mem_waddr (s_mem_waddr),
        .o_mem_wdata (s_mem_wdata)
    );

    pmfb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (s_mem_waddr),
        .i_wdata (s_mem_wdata),
        .i_re    (s_mem_re),
        .i_raddr (s_mem_raddr),
        .o_rdata (s_mem_rdata)
    );

    // take a new result when the output slot is empty or being emptied
    assign s_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_ready) begin
            r_out_valid <= s_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_ready && s_res_valid) begin
            r_out <= s_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### src/pmfb_mem.sv
module pmfb_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/pmfb_walk.sv
`include "paged_mono_framebuffer_engine_core_defines.svh"

module pmfb_walk
    import pmfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output t_out_item       o_res,
    output logic            o_mem_re,
    output logic [$clog2(COLUMNS*PAGES)-1:0] o_mem_raddr,
    input  logic [7:0]      i_mem_rdata,
    output logic            o_mem_we,
    output logic [$clog2(COLUMNS*PAGES)-1:0] o_mem_waddr,
    output logic [7:0]      o_mem_wdata
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]    r_state;
    logic          r_sweep;
    t_in_item      r_item;
    logic [5:0]    r_pg;
    logic [5:0]    r_pg_first;
    logic [5:0]    r_pg_last;
    logic [7:0]    r_ci;
    logic [7:0]    r_ci_last;
    logic          r_rd_hit;
    logic          r_wb_valid;
    logic [1:0]    r_wb_kind;
    logic [7:0]    r_wb_mask;
    logic [AW-1:0] r_wb_addr;

    // set-up of the walk for an item at the input
    logic [5:0] n_pg;
    logic [5:0] n_pg_last;
    logic [7:0] n_ci_last;
    logic       n_empty;

    // current step
    logic [8:0]  s_col;
    logic [7:0]  s_mask;
    logic [1:0]  s_kind;
    logic        s_hit;
    logic [7:0]  s_rows;
    logic [15:0] s_blit;
    logic [7:0]  s_xp;
    logic [7:0]  s_xm;
    logic [7:0]  s_xr;
    logic [7:0]  s_yb;
    logic [15:0] s_addr;

    always_comb begin
        n_pg      = 6'd0;
        n_pg_last = 6'(PAGES - 1);
        n_ci_last = i_in_item.area_width - 8'd1;
        n_empty   = 1'b0;
        case (i_in_item.action)
            ACT_POINT: begin
                n_pg      = {1'b0, i_in_item.y_pos[7:3]};
                n_pg_last = {1'b0, i_in_item.y_pos[7:3]};
                n_ci_last = 8'd0;
            end
            ACT_CLEAR, ACT_INVERT, ACT_FILL: begin
                n_empty = (i_in_item.area_width == 8'd0);
            end
            ACT_OUTLINE: begin
                // zero width: visit column x and the one to its left
                if (i_in_item.area_width == 8'd0) begin
                    n_ci_last = 8'd1;
                end
            end
            ACT_BLIT: begin
                n_pg      = 6'(i_in_item.y_pos[7:3]) + 6'(i_in_item.band);
                n_pg_last = n_pg + ((i_in_item.y_pos[2:0] != 3'd0) ? 6'd1 : 6'd0);
                n_ci_last = 8'd0;
            end
            ACT_READ: begin
                n_pg      = {3'b000, i_in_item.band};
                n_pg_last = {3'b000, i_in_item.band};
                n_ci_last = 8'd0;
            end
            default: begin
                n_ci_last = 8'(COLUMNS - 1);
            end
        endcase
    end

    always_comb begin
        s_rows = f_row_mask(r_pg[2:0], r_item.y_pos, r_item.area_height);
        s_blit = {8'h00, r_item.image_byte} << r_item.y_pos[2:0];
        s_xp   = r_item.x_pos + r_ci;
        s_xm   = r_item.x_pos - r_ci;
        s_xr   = r_item.x_pos + r_item.area_width - 8'd1;
        s_yb   = r_item.y_pos + r_item.area_height - 8'd1;
        s_col  = {1'b0, r_ci};
        s_mask = 8'hFF;
        s_kind = K_XOR;
        if (r_sweep) begin
            s_kind = K_ANDN;
        end else begin
            case (r_item.action)
                ACT_POINT: begin
                    s_col  = {1'b0, r_item.x_pos};
                    s_mask = 8'h01 << r_item.y_pos[2:0];
                    s_kind = K_OR;
                end
                ACT_CLEAR: begin
                    s_col  = {1'b0, s_xp};
                    s_mask = s_rows;
                    s_kind = K_ANDN;
                end
                ACT_INVERT: begin
                    s_col  = {1'b0, s_xp};
                    s_mask = s_rows;
                    s_kind = K_XOR;
                end
                ACT_FILL: begin
                    s_col  = {1'b0, s_xp};
                    s_mask = s_rows;
                    s_kind = K_OR;
                end
                ACT_OUTLINE: begin
                    s_col  = (r_item.area_width == 8'd0) ? {1'b0, s_xm} : {1'b0, s_xp};
                    s_mask = 8'h00;
                    if (r_item.area_width != 8'd0) begin
                        s_mask = f_row_bit(r_pg[2:0], r_item.y_pos)
                               | f_row_bit(r_pg[2:0], s_yb);
                    end
                    if (s_col[7:0] == r_item.x_pos || s_col[7:0] == s_xr) begin
                        s_mask = s_mask | s_rows;
                    end
                    s_kind = K_OR;
                end
                ACT_BLIT: begin
                    s_col  = {1'b0, r_item.x_pos} + {1'b0, r_item.col_offset};
                    s_mask = (r_pg == r_pg_first) ? s_blit[7:0] : s_blit[15:8];
                    s_kind = K_OR;
                end
                ACT_READ: begin
                    s_col  = {1'b0, r_item.x_pos};
                    s_mask = 8'h00;
                    s_kind = K_READ;
                end
                default: begin
                    s_col  = {1'b0, r_ci};
                    s_mask = 8'hFF;
                    s_kind = K_XOR;
                end
            endcase
        end
        s_hit  = (s_col < 9'(COLUMNS)) && (r_pg < 6'(PAGES));
        s_addr = 16'(r_pg[2:0]) * 16'(COLUMNS) + 16'(s_col[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // start the clearing pass over the whole store
            r_state    <= ST_WALK;
            r_sweep    <= 1'b1;
            r_pg       <= 6'd0;
            r_pg_first <= 6'd0;
            r_pg_last  <= 6'(PAGES - 1);
            r_ci       <= 8'd0;
            r_ci_last  <= 8'(COLUMNS - 1);
            r_rd_hit   <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item     <= i_in_item;
                        r_sweep    <= 1'b0;
                        r_rd_hit   <= 1'b0;
                        r_pg       <= n_pg;
                        r_pg_first <= n_pg;
                        r_pg_last  <= n_pg_last;
                        r_ci       <= 8'd0;
                        r_ci_last  <= n_ci_last;
                        r_state    <= n_empty ? ST_FIN : ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (s_hit && s_kind != K_READ) begin
                        r_wb_valid <= 1'b1;
                    end
                    if (s_hit && s_kind == K_READ) begin
                        r_rd_hit <= 1'b1;
                    end
                    r_wb_kind <= s_kind;
                    r_wb_mask <= s_mask;
                    r_wb_addr <= s_addr[AW-1:0];
                    if (r_ci == r_ci_last) begin
                        r_ci <= 8'd0;
                        if (r_pg == r_pg_last) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_pg <= r_pg + 6'd1;
                        end
                    end else begin
                        r_ci <= r_ci + 8'd1;
                    end
                end
                ST_FIN: begin
                    // last write-back lands here; the next item reads only after it
                    if (r_sweep || i_res_ready) begin
                        r_sweep <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (r_wb_kind)
            K_OR:    o_mem_wdata = i_mem_rdata | r_wb_mask;
            K_ANDN:  o_mem_wdata = i_mem_rdata & ~r_wb_mask;
            K_XOR:   o_mem_wdata = i_mem_rdata ^ r_wb_mask;
            default: o_mem_wdata = i_mem_rdata;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_mem_re    = (r_state == ST_WALK) && s_hit;
    assign o_mem_raddr = s_addr[AW-1:0];
    assign o_mem_we    = r_wb_valid;
    assign o_mem_waddr = r_wb_addr;

    assign o_res_valid     = (r_state == ST_FIN) && !r_sweep;
    assign o_res.read_data = r_rd_hit ? i_mem_rdata : 8'h00;
    assign o_res.done_res  = 1'b1;

    `PMFB_ASSERT(a_rw_apart, o_mem_we && o_mem_re, o_mem_waddr != o_mem_raddr, "read and write-back hit the same byte")
    `PMFB_ASSERT(a_wb_after_rd, o_mem_we, $past(o_mem_re), "write-back without a preceding read")
    `PMFB_ASSERT(a_idle_quiet, r_state == ST_IDLE, !o_mem_re && !o_mem_we, "store access while idle")
    `PMFB_ASSERT_NEXT(a_fin_hold, o_res_valid && !i_res_ready, r_state == ST_FIN && o_res_valid, "result dropped under stall")

endmodule

### tb/paged_mono_framebuffer_engine_core_checker.sv
`timescale 1ns / 1ps
module paged_mono_framebuffer_engine_core_checker
    import pmfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    typedef enum logic [1:0] {PIX_SET, PIX_CLR, PIX_FLIP} t_pix_op;

    localparam int ROWS        = PAGES * 8;
    localparam int MAX_PRINTED = 50;

    logic [7:0] pixel_mirror [PAGES][COLUMNS];
    t_out_item  awaited_results [$];
    int         mismatch_tally  = 0;
    int         results_checked = 0;

    task automatic report_mismatch(input string what);
        if (mismatch_tally < MAX_PRINTED) begin
            $display("@%0t result %0d: %s", $time, results_checked, what);
        end
        mismatch_tally++;
    endtask

    function automatic void mark_pixel(input logic [7:0] col, input logic [7:0] row,
                                       input t_pix_op op);
        logic [7:0] mask;
        int         page;
        if (int'(col) >= COLUMNS || int'(row) >= ROWS) begin
            return;
        end
        page = int'(row[7:3]);
        mask = 8'h01 << row[2:0];
        case (op)
            PIX_SET: pixel_mirror[page][col] = pixel_mirror[page][col] | mask;
            PIX_CLR: pixel_mirror[page][col] = pixel_mirror[page][col] & ~mask;
            default: pixel_mirror[page][col] = pixel_mirror[page][col] ^ mask;
        endcase
    endfunction

    // Walk the area with 8-bit wrap on both axes
    function automatic void sweep_area(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] w, input logic [7:0] h,
                                       input t_pix_op op);
        for (int k = 0; k < int'(h); k++) begin
            for (int i = 0; i < int'(w); i++) begin
                mark_pixel(x + 8'(i), y + 8'(k), op);
            end
        end
    endfunction

    function automatic void or_into(input int page, input int col, input logic [7:0] bits);
        if (page >= PAGES || col >= COLUMNS) begin
            return;
        end
        pixel_mirror[page][col] = pixel_mirror[page][col] | bits;
    endfunction

    function automatic t_out_item predict_action_result(input t_in_item cmd);
        t_out_item  res;
        int         col;
        int         page;
        int         shift;
        logic [7:0] low_part;
        logic [7:0] high_part;
        res.read_data = 8'h00;
        res.done_res  = 1'b1;
        case (cmd.action)
            ACT_POINT: begin
                mark_pixel(cmd.x_pos, cmd.y_pos, PIX_SET);
            end
            ACT_CLEAR: begin
                sweep_area(cmd.x_pos, cmd.y_pos, cmd.area_width, cmd.area_height, PIX_CLR);
            end
            ACT_INVERT: begin
                sweep_area(cmd.x_pos, cmd.y_pos, cmd.area_width, cmd.area_height, PIX_FLIP);
            end
            ACT_FILL: begin
                sweep_area(cmd.x_pos, cmd.y_pos, cmd.area_width, cmd.area_height, PIX_SET);
            end
            ACT_OUTLINE: begin
                // sides are drawn even when the other extent is zero
                for (int i = 0; i < int'(cmd.area_width); i++) begin
                    mark_pixel(cmd.x_pos + 8'(i), cmd.y_pos, PIX_SET);
                    mark_pixel(cmd.x_pos + 8'(i), cmd.y_pos + cmd.area_height - 8'd1,
                               PIX_SET);
                end
                for (int i = 0; i < int'(cmd.area_height); i++) begin
                    mark_pixel(cmd.x_pos, cmd.y_pos + 8'(i), PIX_SET);
                    mark_pixel(cmd.x_pos + cmd.area_width - 8'd1, cmd.y_pos + 8'(i),
                               PIX_SET);
                end
            end
            ACT_BLIT: begin
                col       = int'(cmd.x_pos) + int'(cmd.col_offset);
                page      = int'(cmd.y_pos[7:3]) + int'(cmd.band);
                shift     = int'(cmd.y_pos[2:0]);
                low_part  = cmd.image_byte << shift;
                high_part = cmd.image_byte >> (8 - shift);
                if (col < COLUMNS) begin
                    or_into(page, col, low_part);
                    // a byte-aligned image lands in one page only
                    if (shift != 0) begin
                        or_into(page + 1, col, high_part);
                    end
                end
            end
            ACT_READ: begin
                if (int'(cmd.band) < PAGES && int'(cmd.x_pos) < COLUMNS) begin
                    res.read_data = pixel_mirror[cmd.band][cmd.x_pos];
                end
            end
            ACT_INV_ALL: begin
                for (int p = 0; p < PAGES; p++) begin
                    for (int c = 0; c < COLUMNS; c++) begin
                        pixel_mirror[p][c] = pixel_mirror[p][c] ^ 8'hFF;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    pixel_mirror[p][c] = 8'h00;
                end
            end
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result arrived with no item awaiting it");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.read_data !== want.read_data) begin
                        report_mismatch($sformatf("read_data %02h, predicted %02h",
                                                  i_out_item.read_data, want.read_data));
                    end
                    if (i_out_item.done_res !== want.done_res) begin
                        report_mismatch($sformatf("done_res %b, predicted %b",
                                                  i_out_item.done_res, want.done_res));
                    end
                end
                results_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(predict_action_result(i_in_item));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatch_tally;
    end

endmodule

### tb/paged_mono_framebuffer_engine_core_tb.sv
`timescale 1ns / 1ps
module paged_mono_framebuffer_engine_core_tb;
    import pmfb_pkg::*;

    localparam int COLUMNS         = COLUMNS_DEF;
    localparam int PAGES           = PAGES_DEF;
    localparam int ITEM_COUNT      = 1200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 20000;
    // longest single item: a full-width area walk over every page
    localparam int SETTLE_CYCLES   = 255 * PAGES + 2 + 100;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    paged_mono_framebuffer_engine_core #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    paged_mono_framebuffer_engine_core_checker #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item pack_cmd(input logic [2:0] act, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] w,
                                          input logic [7:0] h, input logic [2:0] band,
                                          input logic [7:0] coff, input logic [7:0] img);
        t_in_item cmd;
        cmd.action      = act;
        cmd.x_pos       = x;
        cmd.y_pos       = y;
        cmd.area_width  = w;
        cmd.area_height = h;
        cmd.band        = band;
        cmd.col_offset  = coff;
        cmd.image_byte  = img;
        return cmd;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item cmd;
        int       pick;
        cmd.x_pos       = 8'($urandom);
        cmd.y_pos       = 8'($urandom);
        cmd.area_width  = 8'($urandom);
        cmd.area_height = 8'($urandom);
        cmd.band        = 3'($urandom);
        cmd.col_offset  = 8'($urandom);
        cmd.image_byte  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            cmd.action = ACT_POINT;
        end else if (pick < 38) begin
            cmd.action = ACT_READ;
        end else if (pick < 52) begin
            cmd.action = ACT_BLIT;
        end else if (pick < 62) begin
            cmd.action = ACT_CLEAR;
        end else if (pick < 72) begin
            cmd.action = ACT_INVERT;
        end else if (pick < 82) begin
            cmd.action = ACT_FILL;
        end else if (pick < 97) begin
            cmd.action = ACT_OUTLINE;
        end else begin
            cmd.action = ACT_INV_ALL;
        end
        // keep most traffic near the screen and most areas narrow
        if ($urandom_range(0, 7) != 0) begin
            cmd.x_pos = 8'($urandom_range(0, COLUMNS + 8));
        end
        if ($urandom_range(0, 7) != 0) begin
            cmd.y_pos = 8'($urandom_range(0, PAGES * 8 + 6));
        end
        if ($urandom_range(0, 24) != 0) begin
            cmd.area_width = 8'($urandom_range(0, 12));
        end
        if ($urandom_range(0, 7) != 0) begin
            cmd.area_height = 8'($urandom_range(0, 20));
        end
        if ($urandom_range(0, 5) != 0) begin
            cmd.col_offset = 8'($urandom_range(0, 16));
        end
        return cmd;
    endfunction

    // Hold the item on the channel until it is taken
    task automatic offer(input t_in_item cmd);
        in_item  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : receiver
        int mode;
        int stretch;
        int results_seen;
        bit held_off;
        results_seen = 0;
        held_off     = 1'b0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(1, 80);
            repeat (stretch) begin
                if (out_valid && out_ready) begin
                    results_seen++;
                end
                if (!held_off && results_seen >= 100) begin
                    held_off = 1'b1;
                    // stall long enough for the input side to back up
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_in_item opening [$];
        t_in_item cmd;
        int       burst_left;
        int       gap;
        int       drain_cycles;

        opening.push_back(pack_cmd(ACT_POINT,   8'd0,   8'd0,   8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_POINT,   8'd127, 8'd63,  8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        // points just off the right edge and below the last page
        opening.push_back(pack_cmd(ACT_POINT,   8'd128, 8'd5,   8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_POINT,   8'd3,   8'd64,  8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_READ,    8'd0,   8'd0,   8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_READ,    8'd127, 8'd0,   8'd0,   8'd0,   3'd7,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_FILL,    8'd120, 8'd60,  8'd16,  8'd10,  3'd0,
                                   8'd0,   8'h00));
        // wraps past 255 on both axes
        opening.push_back(pack_cmd(ACT_FILL,    8'd250, 8'd250, 8'd10,  8'd10,  3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_CLEAR,   8'd0,   8'd0,   8'd0,   8'd20,  3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_CLEAR,   8'd2,   8'd0,   8'd4,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_CLEAR,   8'd0,   8'd0,   8'd3,   8'd4,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_INVERT,  8'd0,   8'd2,   8'd8,   8'd12,  3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_OUTLINE, 8'd10,  8'd10,  8'd0,   8'd10,  3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_OUTLINE, 8'd20,  8'd20,  8'd10,  8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_OUTLINE, 8'd40,  8'd30,  8'd1,   8'd1,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_OUTLINE, 8'd0,   8'd0,   8'd128, 8'd64,  3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_BLIT,    8'd5,   8'd16,  8'd0,   8'd0,   3'd0,
                                   8'd0,   8'hA5));
        opening.push_back(pack_cmd(ACT_BLIT,    8'd6,   8'd19,  8'd0,   8'd0,   3'd1,
                                   8'd2,   8'hFF));
        // lower half falls below the last page
        opening.push_back(pack_cmd(ACT_BLIT,    8'd7,   8'd59,  8'd0,   8'd0,   3'd0,
                                   8'd0,   8'hFF));
        opening.push_back(pack_cmd(ACT_BLIT,    8'd120, 8'd0,   8'd0,   8'd0,   3'd2,
                                   8'd10,  8'h3C));
        opening.push_back(pack_cmd(ACT_BLIT,    8'd255, 8'd255, 8'd255, 8'd255, 3'd7,
                                   8'd255, 8'hFF));
        opening.push_back(pack_cmd(ACT_READ,    8'd200, 8'd0,   8'd0,   8'd0,   3'd3,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_INV_ALL, 8'd0,   8'd0,   8'd0,   8'd0,   3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_FILL,    8'd0,   8'd0,   8'd255, 8'd255, 3'd0,
                                   8'd0,   8'h00));
        opening.push_back(pack_cmd(ACT_READ,    8'd8,   8'd0,   8'd0,   8'd0,   3'd3,
                                   8'd0,   8'h00));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < ITEM_COUNT; n++) begin
            cmd = (n < opening.size()) ? opening[n] : random_cmd();
            offer(cmd);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                  : $urandom_range(0, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        for (drain_cycles = 0; pending != 0 && drain_cycles < DRAIN_LIMIT; drain_cycles++) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/pmfb_pkg.sv
src/pmfb_mem.sv
src/pmfb_walk.sv
src/paged_mono_framebuffer_engine_core.sv
tb/paged_mono_framebuffer_engine_core_checker.sv
tb/paged_mono_framebuffer_engine_core_tb.sv
